// ----- rtl/ois_pkg.sv -----
// ----------------------------------------------------------------------------
// ois_pkg
// shared constants, codes and types of the ordered integer set table
// ----------------------------------------------------------------------------
package ois_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;
    localparam int OUT_CNT_W = 5;

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_TEST   = 2'd2,
        FUNC_CLEAR  = 2'd3
    } t_func;

    typedef struct packed {
        logic             add_en;
        logic             rem_en;
        logic [CNT_W-1:0] count;
    } t_cell_ctl;

endpackage

// ----- rtl/ois_chan_if.sv -----
// ----------------------------------------------------------------------------
// ois_chan_if
// request and response channels with valid/ready transfer
// ----------------------------------------------------------------------------
interface ois_req_if;
    import ois_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [1:0]                func;
    logic signed [VAL_W-1:0]   value;

    modport source (output valid, output func, output value, input ready);
    modport sink (input valid, input func, input value, output ready);
endinterface

interface ois_rsp_if;
    import ois_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  ok;
    logic [OUT_CNT_W-1:0]  count;

    modport source (output valid, output ok, output count, input ready);
    modport sink (input valid, input ok, input count, output ready);
endinterface

// ----- rtl/ordered_integer_set_table.sv -----
// ----------------------------------------------------------------------------
// ordered_integer_set_table
// bounded set of distinct integers kept in insertion order, with live count
// ----------------------------------------------------------------------------
// One request transfer per cycle: the response for a request appears in the
// output register in the cycle after it is taken, and the next request is taken
// in that same cycle as long as that register is empty or being drained. The
// period is set by the combinational compare and hit chain that runs through
// all DEPTH cells; a removal shifts every later cell left in that same cycle.
// No clearing pass is needed after reset; only entries below the count are
// ever compared.
module ordered_integer_set_table (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ois_req_if.sink   i_req,
    ois_rsp_if.source o_rsp
);
    import ois_pkg::*;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_valid;
    logic              r_ok;
    logic              n_ok;
    logic [OUT_CNT_W-1:0] r_cnt_out;
    logic [CNT_W+OUT_CNT_W-1:0] w_cnt_ext;

    logic              w_accept;
    logic              w_found;
    logic              w_room;
    t_cell_ctl         w_ctl;
    logic [DEPTH:0]    w_hit;
    logic [VAL_W-1:0]  w_data [DEPTH];

    assign i_req.ready = !r_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_found     = w_hit[DEPTH];
    assign w_room      = r_count < CNT_W'(DEPTH);

    assign w_ctl.add_en = w_accept && (i_req.func == FUNC_ADD) && !w_found && w_room;
    assign w_ctl.rem_en = w_accept && (i_req.func == FUNC_REMOVE) && w_found;
    assign w_ctl.count  = r_count;
    assign w_hit[0]     = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VAL_W-1:0] w_next;
        if (g == DEPTH - 1) begin : g_last
            assign w_next = w_data[g];
        end else begin : g_mid
            assign w_next = w_data[g+1];
        end
        ois_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_idx       (CNT_W'(g)),
            .i_value     (i_req.value),
            .i_next_data (w_next),
            .i_hit       (w_hit[g]),
            .o_hit       (w_hit[g+1]),
            .o_data      (w_data[g])
        );
    end

    always_comb begin
        n_count = r_count;
        n_ok    = 1'b0;
        case (i_req.func)
            FUNC_ADD: begin
                n_ok = w_ctl.add_en;
                if (w_ctl.add_en) n_count = r_count + 1'b1;
            end
            FUNC_REMOVE: begin
                n_ok = w_ctl.rem_en;
                if (w_ctl.rem_en) n_count = r_count - 1'b1;
            end
            FUNC_TEST: begin
                n_ok = w_found;
            end
            default: begin
                n_count = '0;
                n_ok    = 1'b1;
            end
        endcase
    end

    assign w_cnt_ext = {{OUT_CNT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ok      <= n_ok;
            r_cnt_out <= w_cnt_ext[OUT_CNT_W-1:0];
        end
    end

    assign o_rsp.valid = r_valid;
    assign o_rsp.ok    = r_ok;
    assign o_rsp.count = r_cnt_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("member count above depth");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_req.func == FUNC_CLEAR) |=> (r_count == '0) && o_rsp.ok && o_rsp.valid)
        else $error("clear did not empty the set");

    a_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.add_en |=> r_count == $past(r_count) + 1'b1)
        else $error("append did not grow the count");

    a_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.rem_en |=> (r_count == $past(r_count) - 1'b1) && o_rsp.ok)
        else $error("removal did not shrink the count");

    a_no_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctl.add_en && w_ctl.rem_en))
        else $error("append and removal in one cycle");

endmodule

// ----- rtl/ois_cell.sv -----
// ----------------------------------------------------------------------------
// ois_cell
// one entry of the set: compares against the operand, loads on append and
// takes its right neighbor's value once a removal hit lies at or before it
// ----------------------------------------------------------------------------
module ois_cell (
    input  logic                       i_clk,
    input  ois_pkg::t_cell_ctl         i_ctl,
    input  logic [ois_pkg::CNT_W-1:0]  i_idx,
    input  logic [ois_pkg::VAL_W-1:0]  i_value,
    input  logic [ois_pkg::VAL_W-1:0]  i_next_data,
    input  logic                       i_hit,
    output logic                       o_hit,
    output logic [ois_pkg::VAL_W-1:0]  o_data
);
    import ois_pkg::*;

    logic [VAL_W-1:0] r_data;
    logic             w_live;
    logic             w_match;

    assign w_live  = i_idx < i_ctl.count;
    assign w_match = w_live && (r_data == i_value);
    assign o_hit   = i_hit || w_match;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.add_en && (i_idx == i_ctl.count)) begin
            r_data <= i_value;
        end else if (i_ctl.rem_en && o_hit) begin
            r_data <= i_next_data;
        end
    end

endmodule

// ----- tb/ordered_integer_set_table_tb.sv -----
// ----------------------------------------------------------------------------
// ordered_integer_set_table_tb
// self-checking bench for the ordered integer set table: a directed pass over
// duplicate, full, absent and clear cases, then random add, remove, test and
// clear traffic on a small value pool, with random gaps and stalls on both
// channels, every response checked against a tracked copy of the table
// ----------------------------------------------------------------------------
module ordered_integer_set_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ois_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int POOL_SIZE = 24;
    localparam int STALL_LIMIT = 2000;

    typedef struct {
        logic                 ok;
        logic [OUT_CNT_W-1:0] count;
        t_func                func;
    } t_reply;

    class t_set_tracker;
        logic [VAL_W-1:0] members [DEPTH];
        int               member_count;
        t_reply           expected_replies [$];
        int               failures;
        int               op_seen [4];
        int               ok_seen;
        int               full_rejects;

        function int find_member(logic [VAL_W-1:0] v);
            for (int i = 0; i < member_count; i++) begin
                if (members[i] == v) begin
                    return i;
                end
            end
            return -1;
        endfunction

        function void note_request(t_func f, logic [VAL_W-1:0] v);
            int     pos;
            t_reply r;
            pos = find_member(v);
            r.ok = 1'b0;
            r.func = f;
            case (f)
                FUNC_ADD: begin
                    if (member_count < DEPTH && pos < 0) begin
                        members[member_count] = v;
                        member_count++;
                        r.ok = 1'b1;
                    end else if (pos < 0) begin
                        full_rejects++;
                    end
                end
                FUNC_REMOVE: begin
                    if (pos >= 0) begin
                        for (int i = pos; i < member_count - 1; i++) begin
                            members[i] = members[i + 1];
                        end
                        member_count--;
                        r.ok = 1'b1;
                    end
                end
                FUNC_TEST: begin
                    r.ok = (pos >= 0);
                end
                default: begin
                    member_count = 0;
                    r.ok = 1'b1;
                end
            endcase
            r.count = OUT_CNT_W'(member_count);
            expected_replies.push_back(r);
        endfunction

        function void check_response(logic ok, logic [OUT_CNT_W-1:0] cnt);
            t_reply r;
            if (expected_replies.size() == 0) begin
                $error("response with nothing outstanding: ok %0b count %0d", ok, cnt);
                failures++;
                return;
            end
            r = expected_replies.pop_front();
            if (ok !== r.ok) begin
                $error("%s: ok expected %0b actual %0b", r.func.name(), r.ok, ok);
                failures++;
            end
            if (cnt !== r.count) begin
                $error("%s: count expected %0d actual %0d", r.func.name(), r.count, cnt);
                failures++;
            end
            op_seen[r.func]++;
            if (r.ok) begin
                ok_seen++;
            end
        endfunction

        function int outstanding();
            return expected_replies.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    ois_req_if req_ch ();
    ois_rsp_if rsp_ch ();

    ordered_integer_set_table i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    t_set_tracker     tracker = new();
    logic             send_gaps_on;
    logic             recv_stalls_on;
    int               quiet_cycles;
    logic [VAL_W-1:0] value_pool [POOL_SIZE];

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int draw_wait(logic enabled);
        return enabled ? $urandom_range(0, 13) : 0;
    endfunction

    // transfer monitor and watchdog
    always @(posedge i_clk) begin
        if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            tracker.note_request(t_func'(req_ch.func), req_ch.value);
        end
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            tracker.check_response(rsp_ch.ok, rsp_ch.count);
        end
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
                || (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // response sink with random stalls
    initial begin
        int stall;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = draw_wait(recv_stalls_on);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (rsp_ch.valid !== 1'b1) @(posedge i_clk);
        end
    end

    task automatic send_request(t_func f, logic [VAL_W-1:0] v);
        int gap;
        gap = draw_wait(send_gaps_on);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func <= f;
        req_ch.value <= v;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
    endtask

    task automatic drain_replies();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.outstanding() != 0) @(posedge i_clk);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) begin
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else if (r < 90) begin
            return (r < 88) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return $urandom;
    endfunction

    function automatic t_func pick_func();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            return FUNC_ADD;
        end else if (r < 70) begin
            return FUNC_REMOVE;
        end else if (r < 93) begin
            return FUNC_TEST;
        end
        return FUNC_CLEAR;
    endfunction

    initial begin
        int mode;
        i_rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.func <= FUNC_TEST;
        req_ch.value <= '0;
        send_gaps_on = 1'b0;
        recv_stalls_on = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            value_pool[i] = $urandom;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, duplicate, full table, shift on removal, clear
        send_request(FUNC_ADD, 32'h8000_0000);
        send_request(FUNC_ADD, 32'h7FFF_FFFF);
        send_request(FUNC_ADD, 32'h0000_0000);
        send_request(FUNC_ADD, 32'hFFFF_FFFF);
        send_request(FUNC_ADD, 32'h7FFF_FFFF);
        send_request(FUNC_TEST, 32'h8000_0000);
        send_request(FUNC_TEST, 32'h0000_0001);
        for (int i = 4; i < DEPTH; i++) begin
            send_request(FUNC_ADD, 32'd100 + i);
        end
        send_request(FUNC_ADD, 32'h1234_5678);
        send_request(FUNC_REMOVE, 32'h0000_0000);
        send_request(FUNC_TEST, 32'hFFFF_FFFF);
        send_request(FUNC_REMOVE, 32'h0000_0000);
        send_request(FUNC_CLEAR, 32'hFFFF_FFFF);
        send_request(FUNC_TEST, 32'h8000_0000);

        // random traffic, idling pattern changes every 60 transfers
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            mode = (i / 60) % 4;
            send_gaps_on = mode[0];
            recv_stalls_on = mode[1] | (mode == 0);
            if (i == RANDOM_ITEMS / 2) begin
                drain_replies();
            end
            send_request(pick_func(), pick_value());
        end

        drain_replies();
        repeat (4) @(posedge i_clk);
        $display("checked %0d add, %0d remove, %0d test, %0d clear; %0d succeeded",
                 tracker.op_seen[FUNC_ADD], tracker.op_seen[FUNC_REMOVE],
                 tracker.op_seen[FUNC_TEST], tracker.op_seen[FUNC_CLEAR], tracker.ok_seen);
        $display("adds refused on a full table: %0d", tracker.full_rejects);
        if (tracker.failures == 0 && tracker.outstanding() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
